// ===== src/mmi3_pkg.sv =====
package mmi3_pkg;

  localparam int ELEM_W      = 8;
  localparam int MOD_W       = 8;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int STEP_CNT_W  = $clog2(PROD_W + 1);
  localparam int NUM_ELEM    = 9;
  localparam int ELEM_IDX_W  = $clog2(NUM_ELEM);
  localparam int RF_DEPTH    = 22;
  localparam int RF_AW       = $clog2(RF_DEPTH);
  localparam int PROG_LEN    = 51;
  localparam int PC_W        = $clog2(PROG_LEN);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(29);

  // register file map: reduced inputs, adjugate, scratch, determinant and its inverse
  localparam logic [RF_AW-1:0] RF_A00   = RF_AW'(0);
  localparam logic [RF_AW-1:0] RF_A01   = RF_AW'(1);
  localparam logic [RF_AW-1:0] RF_A02   = RF_AW'(2);
  localparam logic [RF_AW-1:0] RF_A10   = RF_AW'(3);
  localparam logic [RF_AW-1:0] RF_A11   = RF_AW'(4);
  localparam logic [RF_AW-1:0] RF_A12   = RF_AW'(5);
  localparam logic [RF_AW-1:0] RF_A20   = RF_AW'(6);
  localparam logic [RF_AW-1:0] RF_A21   = RF_AW'(7);
  localparam logic [RF_AW-1:0] RF_A22   = RF_AW'(8);
  localparam logic [RF_AW-1:0] RF_ADJ00 = RF_AW'(9);
  localparam logic [RF_AW-1:0] RF_ADJ01 = RF_AW'(10);
  localparam logic [RF_AW-1:0] RF_ADJ02 = RF_AW'(11);
  localparam logic [RF_AW-1:0] RF_ADJ10 = RF_AW'(12);
  localparam logic [RF_AW-1:0] RF_ADJ11 = RF_AW'(13);
  localparam logic [RF_AW-1:0] RF_ADJ12 = RF_AW'(14);
  localparam logic [RF_AW-1:0] RF_ADJ20 = RF_AW'(15);
  localparam logic [RF_AW-1:0] RF_ADJ21 = RF_AW'(16);
  localparam logic [RF_AW-1:0] RF_ADJ22 = RF_AW'(17);
  localparam logic [RF_AW-1:0] RF_T0    = RF_AW'(18);
  localparam logic [RF_AW-1:0] RF_T1    = RF_AW'(19);
  localparam logic [RF_AW-1:0] RF_DET   = RF_AW'(20);
  localparam logic [RF_AW-1:0] RF_DINV  = RF_AW'(21);

  // output slots
  localparam logic [RF_AW-1:0] OS_00 = RF_AW'(0);
  localparam logic [RF_AW-1:0] OS_01 = RF_AW'(1);
  localparam logic [RF_AW-1:0] OS_02 = RF_AW'(2);
  localparam logic [RF_AW-1:0] OS_10 = RF_AW'(3);
  localparam logic [RF_AW-1:0] OS_11 = RF_AW'(4);
  localparam logic [RF_AW-1:0] OS_12 = RF_AW'(5);
  localparam logic [RF_AW-1:0] OS_20 = RF_AW'(6);
  localparam logic [RF_AW-1:0] OS_21 = RF_AW'(7);
  localparam logic [RF_AW-1:0] OS_22 = RF_AW'(8);

  typedef struct packed {
    logic [ELEM_W-1:0] a00;
    logic [ELEM_W-1:0] a01;
    logic [ELEM_W-1:0] a02;
    logic [ELEM_W-1:0] a10;
    logic [ELEM_W-1:0] a11;
    logic [ELEM_W-1:0] a12;
    logic [ELEM_W-1:0] a20;
    logic [ELEM_W-1:0] a21;
    logic [ELEM_W-1:0] a22;
  } in_t;

  typedef struct packed {
    logic [MOD_W-1:0] inv00;
    logic [MOD_W-1:0] inv01;
    logic [MOD_W-1:0] inv02;
    logic [MOD_W-1:0] inv10;
    logic [MOD_W-1:0] inv11;
    logic [MOD_W-1:0] inv12;
    logic [MOD_W-1:0] inv20;
    logic [MOD_W-1:0] inv21;
    logic [MOD_W-1:0] inv22;
    logic             invertible;
  } out_t;

  typedef enum logic [2:0] {
    OP_RED,   // raw input mod m -> rf
    OP_MUL,   // (x*y) mod m -> rf
    OP_SUB,   // (x-y) mod m -> rf
    OP_ADD,   // (x+y) mod m -> rf
    OP_SRCH,  // inverse search of x -> rf
    OP_OUT    // (x*y) mod m -> output slot
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [RF_AW-1:0] ra;
    logic [RF_AW-1:0] rb;
    logic [RF_AW-1:0] dst;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             go;
    op_t              op;
    logic [RF_AW-1:0] ra;
    logic [RF_AW-1:0] rb;
    logic [RF_AW-1:0] dst;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_small;
    logic done;
    logic found;
  } dp_stat_t;

  // adjugate entry = p*q - s*t, built as T0, T1, then the difference
  localparam uop_t PROG [PROG_LEN] = '{
    '{OP_RED,  RF_A00,   RF_A00,  RF_A00},
    '{OP_RED,  RF_A01,   RF_A01,  RF_A01},
    '{OP_RED,  RF_A02,   RF_A02,  RF_A02},
    '{OP_RED,  RF_A10,   RF_A10,  RF_A10},
    '{OP_RED,  RF_A11,   RF_A11,  RF_A11},
    '{OP_RED,  RF_A12,   RF_A12,  RF_A12},
    '{OP_RED,  RF_A20,   RF_A20,  RF_A20},
    '{OP_RED,  RF_A21,   RF_A21,  RF_A21},
    '{OP_RED,  RF_A22,   RF_A22,  RF_A22},
    '{OP_MUL,  RF_A11,   RF_A22,  RF_T0},
    '{OP_MUL,  RF_A12,   RF_A21,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ00},
    '{OP_MUL,  RF_A02,   RF_A21,  RF_T0},
    '{OP_MUL,  RF_A01,   RF_A22,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ01},
    '{OP_MUL,  RF_A01,   RF_A12,  RF_T0},
    '{OP_MUL,  RF_A02,   RF_A11,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ02},
    '{OP_MUL,  RF_A12,   RF_A20,  RF_T0},
    '{OP_MUL,  RF_A10,   RF_A22,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ10},
    '{OP_MUL,  RF_A00,   RF_A22,  RF_T0},
    '{OP_MUL,  RF_A02,   RF_A20,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ11},
    '{OP_MUL,  RF_A02,   RF_A10,  RF_T0},
    '{OP_MUL,  RF_A00,   RF_A12,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ12},
    '{OP_MUL,  RF_A10,   RF_A21,  RF_T0},
    '{OP_MUL,  RF_A11,   RF_A20,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ20},
    '{OP_MUL,  RF_A01,   RF_A20,  RF_T0},
    '{OP_MUL,  RF_A00,   RF_A21,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ21},
    '{OP_MUL,  RF_A00,   RF_A11,  RF_T0},
    '{OP_MUL,  RF_A01,   RF_A10,  RF_T1},
    '{OP_SUB,  RF_T0,    RF_T1,   RF_ADJ22},
    '{OP_MUL,  RF_A00,   RF_ADJ00, RF_T0},
    '{OP_MUL,  RF_A01,   RF_ADJ10, RF_T1},
    '{OP_ADD,  RF_T0,    RF_T1,   RF_DET},
    '{OP_MUL,  RF_A02,   RF_ADJ20, RF_T0},
    '{OP_ADD,  RF_DET,   RF_T0,   RF_DET},
    '{OP_SRCH, RF_DET,   RF_DET,  RF_DINV},
    '{OP_OUT,  RF_ADJ00, RF_DINV, OS_00},
    '{OP_OUT,  RF_ADJ01, RF_DINV, OS_01},
    '{OP_OUT,  RF_ADJ02, RF_DINV, OS_02},
    '{OP_OUT,  RF_ADJ10, RF_DINV, OS_10},
    '{OP_OUT,  RF_ADJ11, RF_DINV, OS_11},
    '{OP_OUT,  RF_ADJ12, RF_DINV, OS_12},
    '{OP_OUT,  RF_ADJ20, RF_DINV, OS_20},
    '{OP_OUT,  RF_ADJ21, RF_DINV, OS_21},
    '{OP_OUT,  RF_ADJ22, RF_DINV, OS_22}
  };

endpackage

// ===== src/mmi3_ram.sv =====
module mmi3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/mmi3_modred.sv =====
module mmi3_modred
  import mmi3_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [MOD_W-1:0]  modulus,
  output logic              done,
  output logic [MOD_W-1:0]  result
);

  localparam logic [STEP_CNT_W-1:0] STEPS = STEP_CNT_W'(PROD_W);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [MOD_W-1:0]      rem_r;
  logic [MOD_W-1:0]      rem_nxt;
  logic [PROD_W-1:0]     dvd_r;
  logic [MOD_W:0]        trial;

  // restoring remainder, one dividend bit per cycle; rem stays below modulus
  always_comb begin
    trial = {rem_r, dvd_r[PROD_W-1]};
    if (trial >= {1'b0, modulus}) begin
      rem_nxt = MOD_W'(trial - {1'b0, modulus});
    end else begin
      rem_nxt = MOD_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
    end
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// ===== src/mmi3_dp.sv =====
module mmi3_dp
  import mmi3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [MOD_W-1:0] cfg_data,
  input  in_t              in_data,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output out_t             out_data
);

  logic [MOD_W-1:0]  modulus_r;
  logic [ELEM_W-1:0] raw_r [NUM_ELEM];
  logic [MOD_W-1:0]  inv_r [NUM_ELEM];
  logic              invertible_r;
  op_t               op_r;
  logic [RF_AW-1:0]  dst_r;

  logic [MOD_W-1:0]  rd_a;
  logic [MOD_W-1:0]  rd_b;
  logic              rf_we;
  logic [RF_AW-1:0]  rf_waddr;
  logic [MOD_W-1:0]  rf_wdata;

  logic [MOD_W:0]    sum;
  logic [MOD_W-1:0]  sum_red;
  logic [MOD_W-1:0]  diff_red;
  logic [ELEM_W-1:0] raw_sel;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] dividend;
  logic              mod_start;
  logic              mod_done;
  logic [MOD_W-1:0]  mod_res;

  logic              srch_busy_r;
  logic              srch_done_r;
  logic              found_r;
  logic [MOD_W-1:0]  det_r;
  logic [MOD_W-1:0]  acc_r;
  logic [MOD_W-1:0]  idx_r;
  logic [MOD_W:0]    acc_sum;
  logic [MOD_W-1:0]  acc_step;
  logic              srch_hit;
  logic              srch_end;

  mmi3_ram #(
    .WIDTH (MOD_W),
    .DEPTH (RF_DEPTH)
  ) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .raddr_a (cmd.ra),
    .raddr_b (cmd.rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  mmi3_modred u_modred (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (dividend),
    .modulus  (modulus_r),
    .done     (mod_done),
    .result   (mod_res)
  );

  // combinational add/sub of residues
  always_comb begin
    sum = {1'b0, rd_a} + {1'b0, rd_b};
    if (sum >= {1'b0, modulus_r}) begin
      sum_red = MOD_W'(sum - {1'b0, modulus_r});
    end else begin
      sum_red = MOD_W'(sum);
    end
    if (rd_a >= rd_b) begin
      diff_red = rd_a - rd_b;
    end else begin
      diff_red = rd_a + modulus_r - rd_b;
    end
  end

  always_comb begin
    raw_sel = '0;
    for (int k = 0; k < NUM_ELEM; k++) begin
      if (cmd.ra[ELEM_IDX_W-1:0] == ELEM_IDX_W'(k)) begin
        raw_sel = raw_r[k];
      end
    end
  end

  assign prod      = rd_a * rd_b;
  assign dividend  = (cmd.op == OP_RED) ? PROD_W'(raw_sel) : prod;
  assign mod_start = cmd.go && (cmd.op == OP_RED || cmd.op == OP_MUL || cmd.op == OP_OUT);

  // search walks acc = det*idx mod m
  always_comb begin
    acc_sum = {1'b0, acc_r} + {1'b0, det_r};
    if (acc_sum >= {1'b0, modulus_r}) begin
      acc_step = MOD_W'(acc_sum - {1'b0, modulus_r});
    end else begin
      acc_step = MOD_W'(acc_sum);
    end
    srch_hit = (acc_r == MOD_W'(1));
    srch_end = (idx_r == modulus_r - 1'b1);
  end

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = cmd.dst;
    rf_wdata = sum_red;
    if (cmd.go && (cmd.op == OP_ADD || cmd.op == OP_SUB)) begin
      rf_we    = 1'b1;
      rf_wdata = (cmd.op == OP_ADD) ? sum_red : diff_red;
    end else if (mod_done && op_r != OP_OUT) begin
      rf_we    = 1'b1;
      rf_waddr = dst_r;
      rf_wdata = mod_res;
    end else if (srch_done_r && found_r) begin
      rf_we    = 1'b1;
      rf_waddr = dst_r;
      rf_wdata = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MOD_RESET;
      srch_busy_r  <= 1'b0;
      srch_done_r  <= 1'b0;
      found_r      <= 1'b0;
      invertible_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        modulus_r <= cfg_data;
      end
      srch_done_r <= 1'b0;
      if (cmd.load) begin
        found_r      <= 1'b0;
        invertible_r <= 1'b0;
      end
      if (cmd.go && cmd.op == OP_SRCH) begin
        srch_busy_r <= 1'b1;
        found_r     <= 1'b0;
      end else if (srch_busy_r) begin
        if (srch_hit) begin
          srch_busy_r <= 1'b0;
          srch_done_r <= 1'b1;
          found_r     <= 1'b1;
        end else if (srch_end) begin
          srch_busy_r <= 1'b0;
          srch_done_r <= 1'b1;
        end
      end
      if (srch_done_r && found_r) begin
        invertible_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        inv_r[k] <= '0;
      end
      raw_r[0] <= in_data.a00;
      raw_r[1] <= in_data.a01;
      raw_r[2] <= in_data.a02;
      raw_r[3] <= in_data.a10;
      raw_r[4] <= in_data.a11;
      raw_r[5] <= in_data.a12;
      raw_r[6] <= in_data.a20;
      raw_r[7] <= in_data.a21;
      raw_r[8] <= in_data.a22;
    end
    if (cmd.go) begin
      op_r  <= cmd.op;
      dst_r <= cmd.dst;
    end
    if (mod_done && op_r == OP_OUT) begin
      for (int k = 0; k < NUM_ELEM; k++) begin
        if (dst_r[ELEM_IDX_W-1:0] == ELEM_IDX_W'(k)) begin
          inv_r[k] <= mod_res;
        end
      end
    end
    if (cmd.go && cmd.op == OP_SRCH) begin
      det_r <= rd_a;
      acc_r <= '0;
      idx_r <= '0;
    end else if (srch_busy_r && !srch_hit && !srch_end) begin
      acc_r <= acc_step;
      idx_r <= idx_r + 1'b1;
    end
  end

  assign stat.mod_small = (modulus_r < MOD_W'(2));
  assign stat.done      = mod_done | srch_done_r;
  assign stat.found     = found_r;

  assign out_data.inv00      = inv_r[0];
  assign out_data.inv01      = inv_r[1];
  assign out_data.inv02      = inv_r[2];
  assign out_data.inv10      = inv_r[3];
  assign out_data.inv11      = inv_r[4];
  assign out_data.inv12      = inv_r[5];
  assign out_data.inv20      = inv_r[6];
  assign out_data.inv21      = inv_r[7];
  assign out_data.inv22      = inv_r[8];
  assign out_data.invertible = invertible_r;

endmodule

// ===== src/mmi3_ctrl.sv =====
module mmi3_ctrl
  import mmi3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

  state_t          state_r;
  state_t          state_nxt;
  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uop_t            uop;

  assign uop = PROG[pc_r];

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          pc_nxt    = '0;
          state_nxt = stat.mod_small ? ST_FINISH : ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (uop.op == OP_ADD || uop.op == OP_SUB) begin
          if (pc_r == PC_LAST) begin
            state_nxt = ST_FINISH;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_FETCH;
          end
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          // no inverse: outputs stay cleared
          if ((uop.op == OP_SRCH && !stat.found) || pc_r == PC_LAST) begin
            state_nxt = ST_FINISH;
          end else begin
            pc_nxt    = pc_r + 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load  = (state_r == ST_IDLE) && start;
    cmd.go    = (state_r == ST_EXEC);
    cmd.op    = uop.op;
    cmd.ra    = uop.ra;
    cmd.rb    = uop.rb;
    cmd.dst   = uop.dst;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

// ===== src/modular_matrix_inverse_3x3_unit.sv =====
// Channel  Ports                          Transfer
// input    start, busy, in_data           start && !busy
// result   out_valid, out_data            out_valid, one cycle, no backpressure
// config   cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// A short microprogram runs on one shared modular-reduction unit (one dividend
// bit per cycle, for multiply and reduce ops) and a register-file RAM. The strobe
// comes later for a larger d, the determinant's inverse, if the matrix is invertible,
// or a larger modulus if singular; modulus below two: the cycle after accept.
// Synchronous active-low reset; modulus resets to 29. busy stays high from
// accept through the result strobe.
module modular_matrix_inverse_3x3_unit
  import mmi3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  mmi3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mmi3_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
